// ===== hdl/sshp_pkg.sv =====
// sshp_pkg: shared constants and types for the sparse stencil high-pass filter
// no dependencies
`timescale 1ns / 1ps

package sshp_pkg;

    localparam int LINE_ROWS  = 8;
    localparam int SLOT_BITS  = 3;
    localparam int EDGE       = 4;
    localparam int TAPS       = 9;
    localparam int OUT_BITS   = 16;
    localparam int COORD_BITS = 8;

    localparam logic [OUT_BITS-1:0] BIAS_RESET = 16'd512;

    typedef struct packed {
        logic                  inner;
        logic                  last;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } meta_t;

endpackage

// ===== hdl/sshp_ram.sv =====
// sshp_ram: generic single-write, single-read ram with registered read data
// read-first on a same-address write; no package dependency
`timescale 1ns / 1ps

module sshp_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sshp_tap_cell.sv =====
// sshp_tap_cell: one window column holding the old, middle and current row taps
// uses sshp_pkg; chained nine deep in the top level
`timescale 1ns / 1ps

module sshp_tap_cell
    import sshp_pkg::*;
#(
    parameter int PIXEL_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      shift_en,
    input  logic [3*PIXEL_BITS-1:0]   tap_in,
    output logic [3*PIXEL_BITS-1:0]   tap_out
);

    logic [3*PIXEL_BITS-1:0] tap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else if (shift_en)
        begin
            tap_reg <= tap_in;
        end
    end

    assign tap_out = tap_reg;

endmodule

// ===== hdl/sparse_stencil_highpass_filter.sv =====
// an accepted pixel passes the stage 1, stage 2, stage 3 and output registers
// throughput: one pixel per cycle while in_ready is high, set by the single write and read
// port of each line ram; reset clears position and taps and sets bias to 512, then a
// clearing pass zeroes the eight line rams at every address while in_ready stays low
// uses sshp_pkg, sshp_ram and sshp_tap_cell
`timescale 1ns / 1ps

module sparse_stencil_highpass_filter
    import sshp_pkg::*;
#(
    parameter int FRAME_WIDTH  = 144,
    parameter int FRAME_HEIGHT = 144,
    parameter int PIXEL_BITS   = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [OUT_BITS-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_BITS-1:0]   out_value,
    output logic [COORD_BITS-1:0] out_row,
    output logic [COORD_BITS-1:0] out_col,
    output logic                  frame_last
);

    localparam int CW = $clog2(FRAME_WIDTH);
    localparam int RW = $clog2(FRAME_HEIGHT);
    localparam int PB = PIXEL_BITS;
    localparam int SW = PIXEL_BITS + 3;

    // configuration
    logic [OUT_BITS-1:0] bias_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= BIAS_RESET;
        end
        else if (cfg_valid)
        begin
            bias_reg <= cfg_data;
        end
    end

    // clearing pass
    logic          clr_active_reg;
    logic [CW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CW'(FRAME_WIDTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, en4, accept;

    assign en4      = !out_valid_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1 && !clr_active_reg;
    assign accept   = in_valid && in_ready;

    // stage 0: position and emitted coordinates
    logic [RW-1:0] pos_row_reg, pos_row_next;
    logic [CW-1:0] pos_col_reg, pos_col_next;
    logic [RW-1:0] r0, orow0, sub0;
    logic [CW-1:0] c0, ocol0;
    logic          borrow0;
    logic [SLOT_BITS-1:0] slot_old0;
    meta_t         meta0;

    always_comb
    begin
        r0        = frame_start ? '0 : pos_row_reg;
        c0        = frame_start ? '0 : pos_col_reg;
        borrow0   = c0 < CW'(EDGE);
        ocol0     = borrow0 ? CW'(c0 + CW'(FRAME_WIDTH - EDGE)) : c0 - CW'(EDGE);
        sub0      = RW'(EDGE) + RW'(borrow0);
        orow0     = (r0 >= sub0) ? r0 - sub0 : RW'(r0 + RW'(FRAME_HEIGHT) - sub0);
        slot_old0 = r0[SLOT_BITS-1:0];
        meta0.inner = orow0 >= RW'(EDGE) && orow0 < RW'(FRAME_HEIGHT - EDGE)
                   && ocol0 >= CW'(EDGE) && ocol0 < CW'(FRAME_WIDTH - EDGE);
        meta0.last  = orow0 == RW'(FRAME_HEIGHT - 1) && ocol0 == CW'(FRAME_WIDTH - 1);
        meta0.row   = COORD_BITS'(orow0);
        meta0.col   = COORD_BITS'(ocol0);
        if (c0 == CW'(FRAME_WIDTH - 1))
        begin
            pos_col_next = '0;
            pos_row_next = (r0 == RW'(FRAME_HEIGHT - 1)) ? '0 : r0 + 1'b1;
        end
        else
        begin
            pos_col_next = c0 + 1'b1;
            pos_row_next = r0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_row_reg <= '0;
            pos_col_reg <= '0;
        end
        else if (accept)
        begin
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
        end
    end

    // line store: one ram per row slot
    logic [PB-1:0] ram_rdata [LINE_ROWS];
    logic [CW-1:0] ram_waddr;
    logic [PB-1:0] ram_wdata;

    assign ram_waddr = clr_active_reg ? clr_cnt_reg : c0;
    assign ram_wdata = clr_active_reg ? '0 : pixel;

    for (genvar i = 0; i < LINE_ROWS; i++)
    begin : g_line
        logic ram_we;

        assign ram_we = clr_active_reg || (accept && slot_old0 == SLOT_BITS'(i));

        sshp_ram #(
            .WIDTH (PB),
            .DEPTH (FRAME_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (en1),
            .raddr (c0),
            .rdata (ram_rdata[i])
        );
    end

    // stage 1: ram data returns
    meta_t                meta1_reg;
    logic [PB-1:0]        px1_reg;
    logic [SLOT_BITS-1:0] slot1_reg;
    logic [PB-1:0]        rd_old1, rd_mid1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            meta1_reg <= meta0;
            px1_reg   <= pixel;
            slot1_reg <= slot_old0;
        end
    end

    // the middle row sits four slots away from the oldest
    assign rd_old1 = ram_rdata[slot1_reg];
    assign rd_mid1 = ram_rdata[{~slot1_reg[SLOT_BITS-1], slot1_reg[SLOT_BITS-2:0]}];

    // stage 2: chain of window cells
    logic [3*PB-1:0] tap_chain [TAPS+1];
    logic            tap_shift;

    assign tap_shift    = en2 && v1_reg;
    assign tap_chain[0] = {rd_old1, rd_mid1, px1_reg};

    for (genvar k = 0; k < TAPS; k++)
    begin : g_tap
        sshp_tap_cell #(
            .PIXEL_BITS (PB)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (tap_shift),
            .tap_in   (tap_chain[k]),
            .tap_out  (tap_chain[k+1])
        );
    end

    meta_t meta2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            meta2_reg <= meta1_reg;
        end
    end

    // stage 3: neighbour sum
    logic [3*PB-1:0] t0, t4, t8;
    logic [SW-1:0]   sum_next;

    assign t0 = tap_chain[1];
    assign t4 = tap_chain[5];
    assign t8 = tap_chain[9];

    assign sum_next = SW'(t0[3*PB-1:2*PB]) + SW'(t4[3*PB-1:2*PB]) + SW'(t8[3*PB-1:2*PB])
                    + SW'(t0[2*PB-1:PB]) + SW'(t8[2*PB-1:PB])
                    + SW'(t0[PB-1:0]) + SW'(t4[PB-1:0]) + SW'(t8[PB-1:0]);

    meta_t         meta3_reg;
    logic [SW-1:0] sum3_reg;
    logic [PB-1:0] ctr3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            meta3_reg <= meta2_reg;
            sum3_reg  <= sum_next;
            ctr3_reg  <= t4[2*PB-1:PB];
        end
    end

    // output register
    logic [OUT_BITS-1:0]   value_next;
    logic [OUT_BITS-1:0]   out_value_reg;
    logic [COORD_BITS-1:0] out_row_reg, out_col_reg;
    logic                  frame_last_reg;

    always_comb
    begin
        if (meta3_reg.inner)
        begin
            value_next = bias_reg + OUT_BITS'(ctr3_reg) - OUT_BITS'(sum3_reg >> 3);
        end
        else
        begin
            value_next = bias_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en4)
        begin
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            out_value_reg  <= value_next;
            out_row_reg    <= meta3_reg.row;
            out_col_reg    <= meta3_reg.col;
            frame_last_reg <= meta3_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

endmodule

// ===== hdl/sshp_checker.sv =====
// sshp_checker: port-level assertions for sparse_stencil_highpass_filter
// uses sshp_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module sshp_checker
    import sshp_pkg::*;
#(
    parameter int FRAME_WIDTH  = 144,
    parameter int FRAME_HEIGHT = 144
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [OUT_BITS-1:0]   out_value,
    input logic [COORD_BITS-1:0] out_row,
    input logic [COORD_BITS-1:0] out_col,
    input logic                  frame_last
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
            && $stable(out_row) && $stable(out_col) && $stable(frame_last))
        else $error("output changed while stalled");

    // last flag only on the final position of a frame
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |->
            out_row == COORD_BITS'(FRAME_HEIGHT - 1) && out_col == COORD_BITS'(FRAME_WIDTH - 1))
        else $error("frame_last on wrong position");

    // coordinates stay inside the frame
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (FRAME_WIDTH > 256) || (int'(out_col) < FRAME_WIDTH))
        else $error("out_col outside frame");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (FRAME_HEIGHT > 256) || (int'(out_row) < FRAME_HEIGHT))
        else $error("out_row outside frame");

endmodule

bind sparse_stencil_highpass_filter sshp_checker #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
) u_sshp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
);

// ===== dv/sparse_stencil_highpass_filter_tb.sv =====
// sparse_stencil_highpass_filter_tb: self-checking bench for the stencil high-pass filter,
// predicts output pixels from its own line store, taps and position tracking, or takes them from the directed table
// depends on sshp_pkg and the sparse_stencil_highpass_filter rtl
`timescale 1ns / 1ps

module sparse_stencil_highpass_filter_tb;
    import sshp_pkg::*;

    localparam int FW = 144;
    localparam int FH = 144;
    localparam int PB = 12;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int NDIR = 14;

    typedef struct packed {
        logic [OUT_BITS-1:0]   value;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic [PB-1:0] pixel;
        logic          start;
        logic          fixed;
        result_t       want;
    } pixel_step_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [OUT_BITS-1:0]   cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [PB-1:0]         pixel;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_ready;
    logic [OUT_BITS-1:0]   out_value;
    logic [COORD_BITS-1:0] out_row;
    logic [COORD_BITS-1:0] out_col;
    logic                  frame_last;

    // predictor state
    logic [PB-1:0]       line_mem [LINE_ROWS*FW];
    logic [PB-1:0]       taps_old [TAPS];
    logic [PB-1:0]       taps_mid [TAPS];
    logic [PB-1:0]       taps_new [TAPS];
    int                  cur_row;
    int                  cur_col;
    logic [OUT_BITS-1:0] bias_now;

    result_t pending_results [$];
    result_t head_result;
    int      mismatches = 0;
    int      results_seen = 0;
    int      quiet_cycles = 0;
    logic    calm_in = 1'b0;

    // reset values and edge cases with results read straight off the border rule
    pixel_step_t directed_steps [NDIR] = '{
        '{12'h000, 1'b1, 1'b1, '{16'd512, 8'd139, 8'd140, 1'b0}},
        '{12'hFFF, 1'b0, 1'b1, '{16'd512, 8'd139, 8'd141, 1'b0}},
        '{12'hAAA, 1'b0, 1'b1, '{16'd512, 8'd139, 8'd142, 1'b0}},
        '{12'h555, 1'b0, 1'b1, '{16'd512, 8'd139, 8'd143, 1'b0}},
        '{12'hFFF, 1'b0, 1'b1, '{16'd512, 8'd140, 8'd0, 1'b0}},
        '{12'h001, 1'b0, 1'b1, '{16'd512, 8'd140, 8'd1, 1'b0}},
        '{12'h800, 1'b1, 1'b1, '{16'd512, 8'd139, 8'd140, 1'b0}},
        '{12'h7FF, 1'b1, 1'b1, '{16'd512, 8'd139, 8'd140, 1'b0}},
        '{12'h000, 1'b0, 1'b1, '{16'd512, 8'd139, 8'd141, 1'b0}},
        '{12'hFFF, 1'b0, 1'b0, '0},
        '{12'hFFE, 1'b0, 1'b0, '0},
        '{12'h001, 1'b0, 1'b0, '0},
        '{12'hF0F, 1'b0, 1'b0, '0},
        '{12'h0F0, 1'b1, 1'b1, '{16'd512, 8'd139, 8'd140, 1'b0}}
    };

    sparse_stencil_highpass_filter #(
        .FRAME_WIDTH  (FW),
        .FRAME_HEIGHT (FH),
        .PIXEL_BITS   (PB)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_value   (out_value),
        .out_row     (out_row),
        .out_col     (out_col),
        .frame_last  (frame_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic result_t filter_pixel(input logic [PB-1:0] pv, input logic start);
        int      addr_old;
        int      addr_mid;
        int      orow;
        int      ocol;
        int      sub;
        int      sum;
        int      acc;
        result_t res;
        if (start)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        addr_old = (cur_row % LINE_ROWS) * FW + cur_col;
        addr_mid = ((cur_row + LINE_ROWS - EDGE) % LINE_ROWS) * FW + cur_col;
        for (int k = TAPS - 1; k > 0; k--)
        begin
            taps_old[k] = taps_old[k-1];
            taps_mid[k] = taps_mid[k-1];
            taps_new[k] = taps_new[k-1];
        end
        taps_old[0] = line_mem[addr_old];
        taps_mid[0] = line_mem[addr_mid];
        taps_new[0] = pv;
        line_mem[addr_old] = pv;

        // emitted position trails by four rows and four columns
        if (cur_col < EDGE)
        begin
            ocol = cur_col + FW - EDGE;
            sub  = EDGE + 1;
        end
        else
        begin
            ocol = cur_col - EDGE;
            sub  = EDGE;
        end
        orow = (cur_row >= sub) ? cur_row - sub : cur_row + FH - sub;

        acc = bias_now;
        if (orow >= EDGE && orow < FH - EDGE && ocol >= EDGE && ocol < FW - EDGE)
        begin
            sum = taps_old[0] + taps_old[4] + taps_old[8] + taps_mid[0] + taps_mid[8]
                + taps_new[0] + taps_new[4] + taps_new[8];
            acc = acc + taps_mid[4] - sum / 8;
        end
        res.value = acc[OUT_BITS-1:0];
        res.row   = orow[COORD_BITS-1:0];
        res.col   = ocol[COORD_BITS-1:0];
        res.last  = (orow == FH - 1 && ocol == FW - 1);

        cur_col++;
        if (cur_col >= FW)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= FH)
                cur_row = 0;
        end
        return res;
    endfunction

    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [PB-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PB'($urandom_range(0, (1 << PB) - 1));
        endcase
    endfunction

    task automatic send_pixel(input logic [PB-1:0] pv, input logic start, input logic fixed,
                              input result_t want);
        int      gap;
        result_t res;
        gap = pick_gap(calm_in);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel       <= pv;
        frame_start <= start;
        do @(posedge clk); while (!in_ready);
        res = filter_pixel(pv, start);
        pending_results.push_back(fixed ? want : res);
    endtask

    task automatic run_pixels(input int n, input int start_rate, input logic first_start);
        logic start;
        for (int i = 0; i < n; i++)
        begin
            if (i % 256 == 0)
                calm_in = ($urandom_range(0, 3) == 0);
            start = (i == 0 && first_start) ||
                    (start_rate > 0 && $urandom_range(1, start_rate) == 1);
            send_pixel(random_pixel(), start, 1'b0, '0);
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic write_bias(input logic [OUT_BITS-1:0] v);
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        bias_now = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // output transaction check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result at row %0d col %0d", out_row, out_col);
                mismatches++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (out_value !== head_result.value)
                begin
                    $error("out_value expected %0d actual %0d", head_result.value, out_value);
                    mismatches++;
                end
                if (out_row !== head_result.row)
                begin
                    $error("out_row expected %0d actual %0d", head_result.row, out_row);
                    mismatches++;
                end
                if (out_col !== head_result.col)
                begin
                    $error("out_col expected %0d actual %0d", head_result.col, out_col);
                    mismatches++;
                end
                if (frame_last !== head_result.last)
                begin
                    $error("frame_last expected %0d actual %0d", head_result.last, frame_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // receiver with random stalls and one long hold-off to back up the pipeline
    initial
    begin
        int   stall;
        int   r;
        int   loops;
        logic held;
        logic calm_out;
        held      = 1'b0;
        calm_out  = 1'b0;
        loops     = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (loops % 200 == 0)
                calm_out = ($urandom_range(0, 3) == 0);
            loops++;
            stall = 0;
            r = $urandom_range(0, 99);
            if (!held && results_seen >= 600)
            begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            else if (!calm_out && r < 15)
                stall = $urandom_range(1, 3);
            else if (!calm_out && r < 18)
                stall = $urandom_range(8, 40);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        pixel       = '0;
        frame_start = 1'b0;
        foreach (line_mem[i])
            line_mem[i] = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            taps_old[k] = '0;
            taps_mid[k] = '0;
            taps_new[k] = '0;
        end
        cur_row  = 0;
        cur_col  = 0;
        bias_now = BIAS_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
            send_pixel(directed_steps[i].pixel, directed_steps[i].start,
                       directed_steps[i].fixed, directed_steps[i].want);
        @(negedge clk);
        in_valid <= 1'b0;

        // no frame start from here on, so the position reaches the inner rows
        write_bias(OUT_BITS'($urandom_range(0, 65535)));
        run_pixels(400, 0, 1'b0);
        write_bias('1);
        run_pixels(400, 0, 1'b0);
        write_bias('0);
        run_pixels(420, 0, 1'b0);

        while (pending_results.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sshp_pkg.sv
hdl/sshp_ram.sv
hdl/sshp_tap_cell.sv
hdl/sparse_stencil_highpass_filter.sv
hdl/sshp_checker.sv
dv/sparse_stencil_highpass_filter_tb.sv
